// ----- src/otlmc_pkg.sv -----
`timescale 1ns / 1ps
// otlmc_pkg: types, mode tables and constants for the off-time light mode controller
// no dependencies; used by offtime_light_mode_controller

package otlmc_pkg;

  localparam int SAVE_BYTES_DEF = 32;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;
  localparam int RES_W      = 44;

  localparam logic [7:0] LV_BATT   = 8'd253;
  localparam logic [7:0] LV_STROBE = 8'd254;

  localparam logic [3:0] HIDDEN_MODES   = 4'd3;
  localparam logic [3:0] SOLID_GROUP0   = 4'd7;
  localparam logic [3:0] SOLID_GROUP1   = 4'd4;
  localparam logic [3:0] STEPDOWN_MODE  = 4'd3;
  localparam logic [3:0] PRESS_MAX      = 4'd15;
  localparam logic [3:0] LOW_MAX        = 4'd15;

  localparam logic [7:0] CFG_SHORT_RST  = 8'd250;
  localparam logic [7:0] CFG_MEDIUM_RST = 8'd190;
  localparam logic [7:0] CFG_LOWBAT_RST = 8'd109;
  localparam logic [3:0] CFG_REPEAT_RST = 4'd8;

  typedef enum logic {
    OP_POWER_ON = 1'b0,
    OP_TICK     = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    REG_MEMORY_ENABLE  = 3'd0,
    REG_SHORT_PRESS    = 3'd1,
    REG_MEDIUM_PRESS   = 3'd2,
    REG_LOW_BATTERY    = 3'd3,
    REG_LOW_REPEATS    = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PWM_NONE  = 2'd0,
    PWM_PHASE = 2'd1,
    PWM_FAST  = 2'd2
  } pwm_mode_e;

  localparam logic [7:0] BIG_TAB [2][16] = '{
    '{8'd0, 8'd0, 8'd0, 8'd38, 8'd83, 8'd150, 8'd255, 8'd0,
      8'd253, 8'd254, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd0, 8'd0, 8'd90, 8'd255, 8'd0, 8'd253, 8'd254, 8'd255,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}
  };

  localparam logic [7:0] SMALL_TAB [2][16] = '{
    '{8'd3, 8'd20, 8'd128, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0,
      8'd253, 8'd254, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd20, 8'd160, 8'd0, 8'd255, 8'd0, 8'd253, 8'd254, 8'd255,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}
  };

  localparam pwm_mode_e PWM_TAB [2][16] = '{
    '{PWM_PHASE, PWM_FAST, PWM_FAST, PWM_FAST, PWM_FAST, PWM_FAST, PWM_PHASE, PWM_NONE,
      PWM_PHASE, PWM_PHASE, PWM_PHASE, PWM_NONE, PWM_NONE, PWM_NONE, PWM_NONE, PWM_NONE},
    '{PWM_FAST, PWM_FAST, PWM_FAST, PWM_PHASE, PWM_NONE, PWM_PHASE, PWM_PHASE, PWM_PHASE,
      PWM_NONE, PWM_NONE, PWM_NONE, PWM_NONE, PWM_NONE, PWM_NONE, PWM_NONE, PWM_NONE}
  };

  localparam logic [7:0] BATT_STEPS [5] = '{8'd118, 8'd141, 8'd155, 8'd165, 8'd174};

  typedef struct packed {
    logic [7:0] main_level;
    logic [7:0] aux_level;
    logic       fast_pwm;
  } levels_t;

  // result beat, last member in the lowest bits
  typedef struct packed {
    logic [15:0] save_word;
    logic [4:0]  save_slot;
    logic        save_valid;
    logic        light_off;
    logic [2:0]  blink_count;
    logic        strobe_active;
    logic        fast_pwm;
    logic [7:0]  aux_level;
    logic [7:0]  main_level;
  } result_t;

  function automatic levels_t mode_levels(input logic grp, input logic [3:0] idx);
    levels_t lv;
    lv.main_level = BIG_TAB[grp][idx];
    lv.aux_level  = SMALL_TAB[grp][idx];
    lv.fast_pwm   = (PWM_TAB[grp][idx] == PWM_FAST) &&
                    ((lv.main_level != 8'd0) || (lv.aux_level != 8'd0));
    return lv;
  endfunction

  function automatic logic [15:0] save_word_of(input logic [3:0] mode, input logic grp,
                                               input logic [3:0] presses);
    return {presses, 3'b000, grp, 4'b0000, mode};
  endfunction

endpackage

// ----- src/offtime_light_mode_controller.sv -----
`timescale 1ns / 1ps
// offtime_light_mode_controller: mode selection, tick handling and save slot tracking
// depends on otlmc_pkg
// an input beat passes through the input register, then the result register, to its result beat
// throughput: one event per cycle unless output stalls; state update is one short logic step
// a waiting result lets the input register take one more beat, then input stalls
// reset: mode, presses, group, low count and save position clear to zero, config to defaults

module offtime_light_mode_controller #(
  parameter int SAVE_BYTES = otlmc_pkg::SAVE_BYTES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // cap_level[7:0], voltage_valid[8], voltage_level[16:9], zero fill
  input  logic [otlmc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // opcode[0]
  input  logic [0:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // main_level[7:0], aux_level[15:8], fast_pwm[16], strobe_active[17], blink_count[20:18],
  // light_off[21], save_valid[22], save_slot[27:23], save_word[43:28], zero fill
  output logic [otlmc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [2:0]                        cfg_addr_i,
  input  logic [7:0]                        cfg_data_i
);

  localparam int PosW = $clog2(SAVE_BYTES);
  localparam logic [PosW:0] SaveBytesW = (PosW + 1)'(SAVE_BYTES);

  function automatic logic [PosW-1:0] next_pos(input logic [PosW-1:0] pos);
    logic [PosW:0] sum;
    sum = {1'b0, pos} + (PosW + 1)'(2);
    if (sum >= SaveBytesW) begin
      sum = '0;
    end
    return sum[PosW-1:0];
  endfunction

  // config registers
  logic       mem_en_q;
  logic [7:0] short_thr_q, medium_thr_q, lowbat_thr_q;
  logic [3:0] repeats_q;

  // state
  logic [3:0]      mode_q, mode_d;
  logic [3:0]      presses_q, presses_d;
  logic            group_q, group_d;
  logic            act_group_q, act_group_d;
  logic [3:0]      low_cnt_q, low_cnt_d;
  logic [PosW-1:0] pos_q, pos_d;

  // input and result registers
  logic                     in_vld_q;
  otlmc_pkg::opcode_e       in_op_q;
  logic [7:0]               in_cap_q, in_volt_q;
  logic                     in_vvalid_q;
  logic                     out_vld_q;
  otlmc_pkg::result_t       res_q, res_d;

  logic advance, in_take;

  logic [3:0]        solid;
  logic [3:0]        step_mode;
  logic [7:0]        lvl;
  logic [2:0]        blinks;
  logic              saved;
  logic [15:0]       word;
  logic [PosW+4:0]   slot_ext;
  otlmc_pkg::levels_t lv;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {(otlmc_pkg::OUT_DATA_W - otlmc_pkg::RES_W)'(0), res_q};

  always_comb begin
    mode_d      = mode_q;
    presses_d   = presses_q;
    group_d     = group_q;
    act_group_d = act_group_q;
    low_cnt_d   = low_cnt_q;
    pos_d       = pos_q;
    res_d       = '0;
    saved       = 1'b0;
    word        = '0;
    solid       = '0;
    step_mode   = '0;
    lvl         = '0;
    blinks      = '0;
    lv          = '0;
    slot_ext    = '0;
    if (in_op_q == otlmc_pkg::OP_POWER_ON) begin
      act_group_d = group_q;
      low_cnt_d   = '0;
      solid       = act_group_d ? otlmc_pkg::SOLID_GROUP1 : otlmc_pkg::SOLID_GROUP0;
      if (in_cap_q > short_thr_q) begin
        mode_d = mode_q + 4'd1;
        if (mode_d >= solid) begin
          mode_d = '0;
        end
        if (presses_q != otlmc_pkg::PRESS_MAX) begin
          presses_d = presses_q + 4'd1;
        end
      end else if (in_cap_q > medium_thr_q) begin
        if (mode_q != 4'd0) begin
          mode_d = mode_q - 4'd1;
        end else begin
          mode_d = solid + otlmc_pkg::HIDDEN_MODES;
        end
        if (otlmc_pkg::PWM_TAB[act_group_d][mode_d] == otlmc_pkg::PWM_NONE) begin
          mode_d = '0;
        end
        presses_d = '0;
      end else begin
        presses_d = '0;
        if (!mem_en_q) begin
          mode_d = '0;
        end
      end
      pos_d = next_pos(pos_d);
      word  = otlmc_pkg::save_word_of(mode_d, group_d, presses_d);
      saved = 1'b1;
    end else begin
      lvl   = otlmc_pkg::BIG_TAB[act_group_q][mode_q];
      solid = act_group_q ? otlmc_pkg::SOLID_GROUP1 : otlmc_pkg::SOLID_GROUP0;
      if (presses_q == otlmc_pkg::PRESS_MAX) begin
        presses_d = '0;
        mode_d    = '0;
        group_d   = !group_q;
        pos_d     = next_pos(pos_d);
        word      = otlmc_pkg::save_word_of(mode_d, group_d, presses_d);
        saved     = 1'b1;
        res_d.blink_count = 3'd1;
      end else if (lvl == otlmc_pkg::LV_STROBE) begin
        res_d.main_level    = 8'd255;
        res_d.aux_level     = 8'd255;
        res_d.strobe_active = 1'b1;
      end else if (lvl == otlmc_pkg::LV_BATT) begin
        for (int k = 0; k < 5; k++) begin
          blinks = blinks + 3'(in_volt_q > otlmc_pkg::BATT_STEPS[k]);
        end
        res_d.blink_count = blinks;
      end else begin
        lv = otlmc_pkg::mode_levels(act_group_q, mode_q);
        res_d.main_level = lv.main_level;
        res_d.aux_level  = lv.aux_level;
        res_d.fast_pwm   = lv.fast_pwm;
        presses_d = '0;
        pos_d     = next_pos(pos_d);
        word      = otlmc_pkg::save_word_of(mode_d, group_d, presses_d);
        saved     = 1'b1;
      end
      if (in_vvalid_q) begin
        if (in_volt_q < lowbat_thr_q) begin
          if (low_cnt_q != otlmc_pkg::LOW_MAX) begin
            low_cnt_d = low_cnt_q + 4'd1;
          end
        end else begin
          low_cnt_d = '0;
        end
        if (low_cnt_d >= repeats_q) begin
          // step down one level, hidden modes fall back to a fixed solid mode
          if (mode_d >= solid) begin
            step_mode = otlmc_pkg::STEPDOWN_MODE;
          end else if (mode_d != 4'd0) begin
            step_mode = mode_d - 4'd1;
          end else begin
            step_mode = '0;
          end
          if (mode_d != 4'd0 || mode_d >= solid) begin
            lv = otlmc_pkg::mode_levels(act_group_q, step_mode);
            res_d.main_level = lv.main_level;
            res_d.aux_level  = lv.aux_level;
            res_d.fast_pwm   = lv.fast_pwm;
          end else begin
            res_d.main_level = '0;
            res_d.aux_level  = '0;
            res_d.fast_pwm   = 1'b0;
            res_d.light_off  = 1'b1;
          end
          mode_d    = step_mode;
          pos_d     = next_pos(pos_d);
          word      = otlmc_pkg::save_word_of(mode_d, group_d, presses_d);
          saved     = 1'b1;
          low_cnt_d = '0;
        end
      end
    end
    if (saved) begin
      slot_ext         = (PosW + 5)'(pos_d);
      res_d.save_valid = 1'b1;
      res_d.save_slot  = slot_ext[4:0];
      res_d.save_word  = word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_en_q     <= 1'b0;
      short_thr_q  <= otlmc_pkg::CFG_SHORT_RST;
      medium_thr_q <= otlmc_pkg::CFG_MEDIUM_RST;
      lowbat_thr_q <= otlmc_pkg::CFG_LOWBAT_RST;
      repeats_q    <= otlmc_pkg::CFG_REPEAT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (otlmc_pkg::cfg_reg_e'(cfg_addr_i))
        otlmc_pkg::REG_MEMORY_ENABLE: mem_en_q     <= cfg_data_i[0];
        otlmc_pkg::REG_SHORT_PRESS:   short_thr_q  <= cfg_data_i;
        otlmc_pkg::REG_MEDIUM_PRESS:  medium_thr_q <= cfg_data_i;
        otlmc_pkg::REG_LOW_BATTERY:   lowbat_thr_q <= cfg_data_i;
        otlmc_pkg::REG_LOW_REPEATS:   repeats_q    <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= '0;
      presses_q   <= '0;
      group_q     <= 1'b0;
      act_group_q <= 1'b0;
      low_cnt_q   <= '0;
      pos_q       <= '0;
      in_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q   <= 1'b1;
        mode_q      <= mode_d;
        presses_q   <= presses_d;
        group_q     <= group_d;
        act_group_q <= act_group_d;
        low_cnt_q   <= low_cnt_d;
        pos_q       <= pos_d;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_op_q     <= otlmc_pkg::opcode_e'(s_axis_tuser[0]);
      in_cap_q    <= s_axis_tdata[7:0];
      in_vvalid_q <= s_axis_tdata[8];
      in_volt_q   <= s_axis_tdata[16:9];
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

`ifndef SYNTHESIS
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, pos_q} < SaveBytesW)
    else $error("save position out of range");

  a_pos_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (SAVE_BYTES % 2 != 0) || !pos_q[0])
    else $error("save position odd");

  a_poweron_clears_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_op_q == otlmc_pkg::OP_POWER_ON |=> low_cnt_q == 4'd0)
    else $error("low count not cleared on power-on");

  a_toggle_clears_presses: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_op_q == otlmc_pkg::OP_TICK && presses_q == otlmc_pkg::PRESS_MAX
    |=> presses_q == 4'd0 && group_q != $past(group_q))
    else $error("group toggle did not take effect");

  a_off_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.light_off |-> res_q.main_level == 8'd0 && !res_q.fast_pwm
      && res_q.save_valid)
    else $error("shutdown result not dark or not saved");
`endif

endmodule
